// File: sv/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: sv/crt_pkg.sv
// Types and op codes for the two-moduli CRT solver
package crt_pkg;

    localparam int IN_W  = 16;
    localparam int OUT_W = 32;

    typedef struct packed {
        logic [IN_W-1:0] modulus_n;
        logic [IN_W-1:0] residue_a;
        logic [IN_W-1:0] modulus_m;
        logic [IN_W-1:0] residue_b;
    } crt_in_t;

    typedef struct packed {
        logic             found;
        logic [OUT_W-1:0] solution;
    } crt_out_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_EU,
        OP_EU_MUL,
        OP_EU_UPD,
        OP_DIV_DF,
        OP_CAP_DQ,
        OP_DIV_MM,
        OP_CAP_MM,
        OP_DIV_RU,
        OP_CAP_U,
        OP_DIV_RV,
        OP_CAP_V,
        OP_MUL_UV,
        OP_DIV_T,
        OP_CAP_T,
        OP_MUL_NT,
        OP_ADD_X,
        OP_OUT_OK,
        OP_OUT_NO
    } crt_op_t;

    typedef struct packed {
        crt_op_t op;
    } crt_cmd_t;

    typedef struct packed {
        logic div_done;
        logic rem_zero;
        logic r1_zero;
        logic bad_input;
    } crt_stat_t;

endpackage

// File: sv/crt_div.sv
// Restoring divider, one quotient bit per cycle
module crt_div #(
    parameter int NW  = 32,
    parameter int DVW = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [NW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic           done,
    output logic [NW-1:0]  quo,
    output logic [DVW-1:0] rem
);
    localparam int CW = $clog2(NW);

    logic [NW-1:0]  quo_reg, quo_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [DVW-1:0] dvs_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DVW:0]   rem_sh;
    logic [DVW:0]   trial;
    logic           ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[NW-1]};
        trial     = rem_sh - {1'b0, dvs_reg};
        ge        = !trial[DVW];
        rem_next  = ge ? trial[DVW-1:0] : rem_sh[DVW-1:0];
        quo_next  = {quo_reg[NW-2:0], ge};
        cnt_next  = cnt_reg - CW'(1);
        busy_next = busy_reg && (cnt_reg != '0);
        done_next = busy_reg && (cnt_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NW - 1);
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (busy_reg)
                cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;
endmodule

// File: sv/crt_dp.sv
// Datapath: operand registers, Euclid update, multiplies and the shared divider
module crt_dp #(
    parameter int EW = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  crt_pkg::crt_cmd_t cmd,
    input  crt_pkg::crt_in_t  in_data,
    output crt_pkg::crt_stat_t stat,
    output crt_pkg::crt_out_t out_data
);
    import crt_pkg::*;

    localparam int SW = EW + 2;        // Bezout coefficient, signed
    localparam int DW = 2 * EW;        // wide products and dividends
    localparam int PW = EW + 1 + SW;   // q * s1

    logic [EW-1:0]        n_reg, a_reg, m_reg, b_reg;
    logic [EW-1:0]        r0_reg, r1_reg, rn_reg;
    logic signed [SW-1:0] s0_reg, s1_reg;
    logic signed [PW-1:0] prod_reg;
    logic [EW-1:0]        dq_reg, mm_reg, u_reg, v_reg, t_reg;
    logic [DW-1:0]        uv_reg, nt_reg, x_reg;
    logic                 found_reg;
    logic [OUT_W-1:0]     sol_reg;

    logic                 div_start;
    logic [DW-1:0]        div_nd;
    logic [EW-1:0]        div_dv;
    logic                 div_done;
    logic [DW-1:0]        div_q;
    logic [EW-1:0]        div_r;

    logic                 diff_neg;
    logic [EW-1:0]        diff_abs;
    logic                 s0_neg;
    logic [SW-1:0]        s0_abs;
    logic signed [PW-1:0] s1_next;
    logic [EW-1:0]        red_rem;

    always_comb
    begin
        diff_neg = a_reg > b_reg;
        diff_abs = diff_neg ? (a_reg - b_reg) : (b_reg - a_reg);
        s0_neg   = s0_reg[SW-1];
        s0_abs   = s0_neg ? SW'(-s0_reg) : SW'(s0_reg);
        s1_next  = PW'(s0_reg) - prod_reg;
        // remainder folded back to [0, mm) for a negative operand
        red_rem  = mm_reg - div_r;
    end

    always_comb
    begin
        div_start = 1'b1;
        div_nd    = '0;
        div_dv    = mm_reg;
        unique case (cmd.op)
            OP_DIV_EU:
            begin
                div_nd = DW'(r0_reg);
                div_dv = r1_reg;
            end
            OP_DIV_DF:
            begin
                div_nd = DW'(diff_abs);
                div_dv = r0_reg;
            end
            OP_DIV_MM:
            begin
                div_nd = DW'(m_reg);
                div_dv = r0_reg;
            end
            OP_DIV_RU: div_nd = DW'(dq_reg);
            OP_DIV_RV: div_nd = DW'(s0_abs[EW-1:0]);
            OP_DIV_T:  div_nd = uv_reg;
            default:   div_start = 1'b0;
        endcase
    end

    crt_div #(
        .NW  (DW),
        .DVW (EW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_nd),
        .divisor  (div_dv),
        .done     (div_done),
        .quo      (div_q),
        .rem      (div_r)
    );

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                n_reg  <= in_data.modulus_n[EW-1:0];
                a_reg  <= in_data.residue_a[EW-1:0];
                m_reg  <= in_data.modulus_m[EW-1:0];
                b_reg  <= in_data.residue_b[EW-1:0];
                r0_reg <= in_data.modulus_n[EW-1:0];
                r1_reg <= in_data.modulus_m[EW-1:0];
                s0_reg <= SW'(1);
                s1_reg <= '0;
            end
            OP_EU_MUL:
            begin
                prod_reg <= PW'($signed({1'b0, div_q[EW-1:0]}) * s1_reg);
                rn_reg   <= div_r;
            end
            OP_EU_UPD:
            begin
                s0_reg <= s1_reg;
                s1_reg <= SW'(s1_next);
                r0_reg <= r1_reg;
                r1_reg <= rn_reg;
            end
            OP_CAP_DQ: dq_reg <= div_q[EW-1:0];
            OP_CAP_MM: mm_reg <= div_q[EW-1:0];
            OP_CAP_U:  u_reg  <= (diff_neg && div_r != '0) ? red_rem : div_r;
            OP_CAP_V:  v_reg  <= (s0_neg && div_r != '0) ? red_rem : div_r;
            OP_MUL_UV: uv_reg <= u_reg * v_reg;
            OP_CAP_T:  t_reg  <= div_r;
            OP_MUL_NT: nt_reg <= n_reg * t_reg;
            OP_ADD_X:  x_reg  <= nt_reg + DW'(a_reg);
            OP_OUT_OK:
            begin
                found_reg <= 1'b1;
                sol_reg   <= OUT_W'(x_reg);
            end
            OP_OUT_NO:
            begin
                found_reg <= 1'b0;
                sol_reg   <= '0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        stat.div_done  = div_done;
        stat.rem_zero  = (div_r == '0);
        stat.r1_zero   = (r1_reg == '0);
        stat.bad_input = (n_reg == '0) || (m_reg == '0) || (a_reg >= n_reg)
                       || (b_reg >= m_reg);
        out_data.found    = found_reg;
        out_data.solution = sol_reg;
    end
endmodule

// File: sv/crt_ctrl.sv
// Controller: sequences the solver steps and owns the handshakes
module crt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  crt_pkg::crt_stat_t  stat,
    output crt_pkg::crt_cmd_t   cmd
);
    import crt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_EU_TEST, S_EU_WAIT, S_EU_UPD,
        S_DF_WAIT, S_MM_GO, S_MM_WAIT, S_RU_GO, S_RU_WAIT,
        S_RV_GO, S_RV_WAIT, S_UV_MUL, S_T_GO, S_T_WAIT,
        S_NT_MUL, S_X_ADD, S_FIN_OK, S_FIN_NO
    } state_t;

    state_t  state_reg, state_next;
    logic    out_valid_reg, out_valid_next;
    crt_op_t op;
    logic    out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        op             = OP_NOP;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_CHECK;
                end
            S_CHECK:
                state_next = stat.bad_input ? S_FIN_NO : S_EU_TEST;
            S_EU_TEST:
                if (stat.r1_zero)
                begin
                    op         = OP_DIV_DF;
                    state_next = S_DF_WAIT;
                end
                else
                begin
                    op         = OP_DIV_EU;
                    state_next = S_EU_WAIT;
                end
            S_EU_WAIT:
                if (stat.div_done)
                begin
                    op         = OP_EU_MUL;
                    state_next = S_EU_UPD;
                end
            S_EU_UPD:
            begin
                op         = OP_EU_UPD;
                state_next = S_EU_TEST;
            end
            S_DF_WAIT:
                if (stat.div_done)
                begin
                    if (stat.rem_zero)
                    begin
                        op         = OP_CAP_DQ;
                        state_next = S_MM_GO;
                    end
                    else
                        state_next = S_FIN_NO;
                end
            S_MM_GO:
            begin
                op         = OP_DIV_MM;
                state_next = S_MM_WAIT;
            end
            S_MM_WAIT:
                if (stat.div_done)
                begin
                    op         = OP_CAP_MM;
                    state_next = S_RU_GO;
                end
            S_RU_GO:
            begin
                op         = OP_DIV_RU;
                state_next = S_RU_WAIT;
            end
            S_RU_WAIT:
                if (stat.div_done)
                begin
                    op         = OP_CAP_U;
                    state_next = S_RV_GO;
                end
            S_RV_GO:
            begin
                op         = OP_DIV_RV;
                state_next = S_RV_WAIT;
            end
            S_RV_WAIT:
                if (stat.div_done)
                begin
                    op         = OP_CAP_V;
                    state_next = S_UV_MUL;
                end
            S_UV_MUL:
            begin
                op         = OP_MUL_UV;
                state_next = S_T_GO;
            end
            S_T_GO:
            begin
                op         = OP_DIV_T;
                state_next = S_T_WAIT;
            end
            S_T_WAIT:
                if (stat.div_done)
                begin
                    op         = OP_CAP_T;
                    state_next = S_NT_MUL;
                end
            S_NT_MUL:
            begin
                op         = OP_MUL_NT;
                state_next = S_X_ADD;
            end
            S_X_ADD:
            begin
                op         = OP_ADD_X;
                state_next = S_FIN_OK;
            end
            S_FIN_OK:
                if (out_free)
                begin
                    op             = OP_OUT_OK;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            S_FIN_NO:
                if (out_free)
                begin
                    op             = OP_OUT_NO;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.op    = op;
endmodule

// File: sv/crt_two_moduli_solver.sv
// Top level of the two-moduli CRT solver
//
//   channel | direction | handshake           | payload
//   in      | to block  | in_valid, in_stall   | in_data  (crt_in_t)
//   out     | from block| out_valid, out_stall | out_data (crt_out_t)
//
// One item at a time; every Euclid step and every later division of an item runs
// in turn on the shared bit-serial divider. Invalid inputs finish right after the
// check; incompatible ones right after the divisibility test.
// Reset is asynchronous and clears the controller and divider sequencing only.
// A new item is taken while a finished result still waits on out_stall.
`include "assert_macros.svh"

module crt_two_moduli_solver #(
    parameter int WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  crt_pkg::crt_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output crt_pkg::crt_out_t out_data
);
    import crt_pkg::*;

    localparam int EW = (WIDTH < IN_W) ? WIDTH : IN_W;

    crt_cmd_t  cmd;
    crt_stat_t stat;

    crt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    crt_dp #(
        .EW (EW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .stat     (stat),
        .out_data (out_data)
    );

    `ASSERT_IMPLY(a_nofound_zero, clk, rst_n, out_valid && !out_data.found, out_data.solution == '0)
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

// File: sim/crt_two_moduli_checker.sv
// Result checker for the two-moduli CRT solver
`timescale 1ns / 100ps

module crt_two_moduli_checker
    import crt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_stall,
    input  crt_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_stall,
    input  crt_out_t out_data,
    output int       fail_count,
    output int       pending
);

    crt_out_t solution_queue[$];

    // least non-negative x for the pair of congruences, or not found
    function automatic crt_out_t solve_congruences(crt_in_t item);
        crt_out_t  res;
        longint    r0, r1, s0, s1, qt, rn, sn;
        longint    n, a, m, b, diff, mm, u, v, t;
        n = item.modulus_n;
        a = item.residue_a;
        m = item.modulus_m;
        b = item.residue_b;
        res = '0;
        if (n == 0 || m == 0 || a >= n || b >= m)
            return res;
        r0 = n;
        r1 = m;
        s0 = 1;
        s1 = 0;
        while (r1 != 0)
        begin
            qt = r0 / r1;
            rn = r0 - qt * r1;
            sn = s0 - qt * s1;
            r0 = r1;
            r1 = rn;
            s0 = s1;
            s1 = sn;
        end
        diff = b - a;
        if (diff % r0 != 0)
            return res;
        mm = m / r0;
        u = (diff / r0) % mm;
        if (u < 0)
            u += mm;
        v = s0 % mm;
        if (v < 0)
            v += mm;
        t = (u * v) % mm;
        res.found = 1'b1;
        res.solution = 32'(a + n * t);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
    end

    assign pending = solution_queue.size();

    always @(posedge clk)
    begin
        crt_out_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                solution_queue.push_back(solve_congruences(in_data));
            if (out_valid && !out_stall)
            begin
                if (solution_queue.size() == 0)
                    report_mismatch("result with no item pending");
                else
                begin
                    want = solution_queue.pop_front();
                    if (out_data.found !== want.found)
                        report_mismatch($sformatf("found %b, want %b",
                            out_data.found, want.found));
                    if (out_data.solution !== want.solution)
                        report_mismatch($sformatf("solution %0d, want %0d",
                            out_data.solution, want.solution));
                end
            end
        end
    end

endmodule

// File: sim/crt_two_moduli_solver_tb.sv
// Testbench top for the two-moduli CRT solver
`timescale 1ns / 100ps

module crt_two_moduli_solver_tb;
    import crt_pkg::*;

    localparam int RANDOM_ITEMS = 830;
    localparam int CYCLE_LIMIT  = 5000000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    crt_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    crt_out_t out_data;
    int       fail_count;
    int       pending;
    int       cycle_count;
    bit       hold_off;

    crt_two_moduli_solver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    crt_two_moduli_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** crt_two_moduli_solver: FAILED **");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off when asked
    always @(posedge clk)
    begin
        int mode;
        mode = $urandom_range(0, 99);
        if (hold_off)
            out_stall <= 1'b1;
        else if (cycle_count % 3000 < 800)
            out_stall <= 1'b0;
        else
            out_stall <= (mode < 40);
    end

    initial
    begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
    end

    // small moduli in at least half of the picks so that solutions exist often
    function automatic logic [15:0] pick_modulus();
        unique case ($urandom_range(0, 3))
            0: return 16'($urandom_range(1, 12));
            1: return 16'($urandom_range(1, 300));
            2: return 16'($urandom_range(1, 65535));
            default: return 16'($urandom_range(0, 255)) << $urandom_range(0, 8);
        endcase
    endfunction

    function automatic crt_in_t random_congruence();
        crt_in_t item;
        logic [15:0] g;
        item.modulus_n = pick_modulus();
        item.modulus_m = pick_modulus();
        if ($urandom_range(0, 3) == 0)
        begin
            // share a factor so gcd is above one
            g = 16'($urandom_range(2, 40));
            item.modulus_n = 16'($urandom_range(1, 1600)) * g;
            item.modulus_m = 16'($urandom_range(1, 1600)) * g;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            item.residue_a = 16'($urandom);
            item.residue_b = 16'($urandom);
        end
        else
        begin
            item.residue_a = (item.modulus_n == 0) ? 16'd0
                : 16'($urandom % item.modulus_n);
            item.residue_b = (item.modulus_m == 0) ? 16'd0
                : 16'($urandom % item.modulus_m);
        end
        return item;
    endfunction

    task automatic send_item(input crt_in_t item);
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_gap();
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    initial
    begin
        crt_in_t directed[$];
        int      burst;
        bit      drained;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cycle_count = 0;
        rst_n       = 1'b0;
        drained     = 1'b0;
        directed = '{
            '{16'd3, 16'd2, 16'd5, 16'd3},
            '{16'd4, 16'd1, 16'd6, 16'd3},
            '{16'd4, 16'd0, 16'd6, 16'd3},
            '{16'd0, 16'd0, 16'd5, 16'd1},
            '{16'd5, 16'd1, 16'd0, 16'd0},
            '{16'd5, 16'd5, 16'd7, 16'd1},
            '{16'd5, 16'd1, 16'd7, 16'd9},
            '{16'd1, 16'd0, 16'd1, 16'd0},
            '{16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFD},
            '{16'hFFFF, 16'd0, 16'hFFFF, 16'd0},
            '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
            '{16'hFFFF, 16'h1234, 16'hFFFF, 16'h1234},
            '{16'hFFFF, 16'h1234, 16'hFFFF, 16'h1235},
            '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001},
            '{16'd1, 16'd0, 16'hFFFF, 16'hAAAA},
            '{16'd12, 16'd5, 16'd18, 16'd11},
            '{16'd12, 16'd11, 16'd18, 16'd5},
            '{16'hFFFF, 16'h5555, 16'hFFFE, 16'hAAAA},
            '{16'hFFF1, 16'hFFF0, 16'hFFFB, 16'hFFFA},
            '{16'd7, 16'd6, 16'd7, 16'd6}
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_item(directed[i]);
        for (int sent = 0; sent < RANDOM_ITEMS; sent++)
        begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++, sent++)
                send_item(random_congruence());
            sent--;
            send_gap();
            if (!drained && sent >= RANDOM_ITEMS / 2)
            begin
                // drain to empty before going on
                drained = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("** crt_two_moduli_solver: PASSED **");
        else
            $display("** crt_two_moduli_solver: FAILED **");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/crt_pkg.sv
sv/crt_div.sv
sv/crt_dp.sv
sv/crt_ctrl.sv
sv/crt_two_moduli_solver.sv
sim/crt_two_moduli_checker.sv
sim/crt_two_moduli_solver_tb.sv
